@@ hdl/tfc_pkg.sv @@
// Shared codes, widths and directory control types for the two-level FIFO cache.
`timescale 1ns / 1ps
package tfc_pkg;

    localparam int ADDR_W = 10;
    localparam int DATA_W = 32;

    // command codes
    localparam logic [1:0] CMD_READ    = 2'd0;
    localparam logic [1:0] CMD_WRITE   = 2'd1;
    localparam logic [1:0] CMD_PRELOAD = 2'd2;

    // hit level codes
    localparam logic [1:0] LVL_L1   = 2'd0;
    localparam logic [1:0] LVL_L2   = 2'd1;
    localparam logic [1:0] LVL_MISS = 2'd2;
    localparam logic [1:0] LVL_NONE = 2'd3;

    // register index
    localparam logic REG_WRITE_POLICY = 1'b0;

    typedef struct packed {
        logic ins_l1;     // append new entry at L1 tail
        logic ins_l2;     // append new entry at L2 tail
        logic rotate;     // L1 head -> L2 head slot, new entry -> L1 head slot
        logic dirty_l1;   // mark the L1 hit entry dirty
        logic dirty_l2;   // mark the L2 hit entry dirty
        logic new_dirty;  // dirty flag of an inserted entry
    } t_dir_req;

    typedef struct packed {
        logic l1_hit;
        logic l2_hit;
        logic l1_full;
        logic l2_full;
        logic l2_head_dirty;
    } t_dir_stat;

endpackage

@@ hdl/tfc_dir.sv @@
// Tag directory: tags and flags in flip-flops, parallel compare, FIFO pointers.
`timescale 1ns / 1ps
module tfc_dir #(
    parameter int L1_ENTRIES = 64,
    parameter int L2_ENTRIES = 128,
    localparam int I1W = $clog2(L1_ENTRIES),
    localparam int I2W = $clog2(L2_ENTRIES)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cmp,
    input  logic [tfc_pkg::ADDR_W-1:0]   i_addr,
    input  tfc_pkg::t_dir_req            i_req,
    output tfc_pkg::t_dir_stat           o_stat,
    output logic [I1W-1:0]               o_l1_idx,
    output logic [I2W-1:0]               o_l2_idx,
    output logic [I1W-1:0]               o_l1_tail,
    output logic [I2W-1:0]               o_l2_tail,
    output logic [I1W-1:0]               o_l1_head,
    output logic [I2W-1:0]               o_l2_head,
    output logic [tfc_pkg::ADDR_W-1:0]   o_l2_head_tag
);
    import tfc_pkg::*;

    localparam int C1W = $clog2(L1_ENTRIES + 1);
    localparam int C2W = $clog2(L2_ENTRIES + 1);

    logic [ADDR_W-1:0] r_l1_tag [L1_ENTRIES];
    logic [ADDR_W-1:0] r_l2_tag [L2_ENTRIES];
    logic [L1_ENTRIES-1:0] r_l1_v, r_l1_d, r_l1_hv;
    logic [L2_ENTRIES-1:0] r_l2_v, r_l2_d, r_l2_hv;
    logic [I1W-1:0] r_l1_head, r_l1_idx, n_l1_idx, l1_head_inc, l1_tail;
    logic [I2W-1:0] r_l2_head, r_l2_idx, n_l2_idx, l2_head_inc, l2_tail;
    logic [C1W-1:0] r_l1_cnt;
    logic [C2W-1:0] r_l2_cnt;
    logic [C1W:0]   sum1;
    logic [C2W:0]   sum2;
    logic           r_l1_hit, r_l2_hit, l1_full, l2_full;

    // hit vectors are one-hot at most, so an OR of indices encodes them
    always_comb begin
        n_l1_idx = '0;
        n_l2_idx = '0;
        for (int i = 0; i < L1_ENTRIES; i++)
            if (r_l1_hv[i]) n_l1_idx = n_l1_idx | I1W'(i);
        for (int j = 0; j < L2_ENTRIES; j++)
            if (r_l2_hv[j]) n_l2_idx = n_l2_idx | I2W'(j);
    end

    always_comb begin
        sum1 = (C1W+1)'(r_l1_head) + (C1W+1)'(r_l1_cnt);
        sum2 = (C2W+1)'(r_l2_head) + (C2W+1)'(r_l2_cnt);
        l1_tail = (sum1 >= (C1W+1)'(L1_ENTRIES)) ? I1W'(sum1 - (C1W+1)'(L1_ENTRIES))
                                                 : I1W'(sum1);
        l2_tail = (sum2 >= (C2W+1)'(L2_ENTRIES)) ? I2W'(sum2 - (C2W+1)'(L2_ENTRIES))
                                                 : I2W'(sum2);
        l1_head_inc = (r_l1_head == I1W'(L1_ENTRIES - 1)) ? '0 : r_l1_head + 1'b1;
        l2_head_inc = (r_l2_head == I2W'(L2_ENTRIES - 1)) ? '0 : r_l2_head + 1'b1;
        l1_full = (r_l1_cnt == C1W'(L1_ENTRIES));
        l2_full = (r_l2_cnt == C2W'(L2_ENTRIES));
    end

    // tags carry no reset
    always_ff @(posedge i_clk) begin
        if (i_req.ins_l1) r_l1_tag[l1_tail] <= i_addr;
        if (i_req.ins_l2) r_l2_tag[l2_tail] <= i_addr;
        if (i_req.rotate) begin
            r_l2_tag[r_l2_head] <= r_l1_tag[r_l1_head];
            r_l1_tag[r_l1_head] <= i_addr;
        end
        r_l1_idx <= n_l1_idx;
        r_l2_idx <= n_l2_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l1_v    <= '0;
            r_l1_d    <= '0;
            r_l2_v    <= '0;
            r_l2_d    <= '0;
            r_l1_hv   <= '0;
            r_l2_hv   <= '0;
            r_l1_hit  <= 1'b0;
            r_l2_hit  <= 1'b0;
            r_l1_head <= '0;
            r_l2_head <= '0;
            r_l1_cnt  <= '0;
            r_l2_cnt  <= '0;
        end else begin
            if (i_cmp) begin
                for (int i = 0; i < L1_ENTRIES; i++)
                    r_l1_hv[i] <= r_l1_v[i] && (r_l1_tag[i] == i_addr);
                for (int j = 0; j < L2_ENTRIES; j++)
                    r_l2_hv[j] <= r_l2_v[j] && (r_l2_tag[j] == i_addr);
            end
            r_l1_hit <= |r_l1_hv;
            r_l2_hit <= |r_l2_hv;
            if (i_req.ins_l1) begin
                r_l1_v[l1_tail] <= 1'b1;
                r_l1_d[l1_tail] <= i_req.new_dirty;
                r_l1_cnt        <= r_l1_cnt + 1'b1;
            end
            if (i_req.ins_l2) begin
                r_l2_v[l2_tail] <= 1'b1;
                r_l2_d[l2_tail] <= i_req.new_dirty;
                r_l2_cnt        <= r_l2_cnt + 1'b1;
            end
            if (i_req.rotate) begin
                r_l2_v[r_l2_head] <= r_l1_v[r_l1_head];
                r_l2_d[r_l2_head] <= r_l1_d[r_l1_head];
                r_l1_v[r_l1_head] <= 1'b1;
                r_l1_d[r_l1_head] <= i_req.new_dirty;
                r_l1_head         <= l1_head_inc;
                r_l2_head         <= l2_head_inc;
            end
            if (i_req.dirty_l1) r_l1_d[r_l1_idx] <= 1'b1;
            if (i_req.dirty_l2) r_l2_d[r_l2_idx] <= 1'b1;
        end
    end

    assign o_stat.l1_hit        = r_l1_hit;
    assign o_stat.l2_hit        = r_l2_hit;
    assign o_stat.l1_full       = l1_full;
    assign o_stat.l2_full       = l2_full;
    assign o_stat.l2_head_dirty = r_l2_d[r_l2_head];
    assign o_l1_idx      = r_l1_idx;
    assign o_l2_idx      = r_l2_idx;
    assign o_l1_tail     = l1_tail;
    assign o_l2_tail     = l2_tail;
    assign o_l1_head     = r_l1_head;
    assign o_l2_head     = r_l2_head;
    assign o_l2_head_tag = r_l2_tag[r_l2_head];

    // an address lives in at most one slot of either level
    a_l1_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n) $onehot0(r_l1_hv))
        else $error("multiple L1 tag hits");
    a_l2_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n) $onehot0(r_l2_hv))
        else $error("multiple L2 tag hits");
    a_rotate_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.rotate |-> (l1_full && l2_full))
        else $error("rotate with a level not full");
    a_single_ins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_req.ins_l1, i_req.ins_l2, i_req.rotate}))
        else $error("conflicting insert requests");

endmodule

@@ hdl/two_level_fifo_cache_unit.sv @@
// Top level: sequencer, word memories, backing store and register port.
`timescale 1ns / 1ps
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------------------
//  in      | in        | i_in_valid / o_in_ready    | i_cmd, i_address, i_write_data
//  out     | out       | o_out_valid / i_out_ready  | o_read_data, o_hit_level, o_wrote_back
//  apb     | in        | psel, penable, pwrite      | paddr, pwdata, prdata, pready
//
//  Each item steps through S_CMP and S_ENC (tag compare, then encode, in the directory)
//  and S_ACT, then S_OUT; a read adds S_RDW for the registered word RAM read, a miss
//  adds S_INS for the insert, and a miss that evicts adds S_EV as well.
//  After reset the backing store is zeroed, one word a cycle, with o_in_ready low
//  until it is done. The result sits in an output register; the sequencer only waits
//  when that register is still full and the next result is ready.
//
module two_level_fifo_cache_unit #(
    parameter int L1_ENTRIES = 64,
    parameter int L2_ENTRIES = 128,
    parameter int MEM_WORDS  = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_cmd,
    input  logic [9:0]         i_address,
    input  logic signed [31:0] i_write_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_read_data,
    output logic [1:0]         o_hit_level,
    output logic               o_wrote_back,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import tfc_pkg::*;

    localparam int I1W = $clog2(L1_ENTRIES);
    localparam int I2W = $clog2(L2_ENTRIES);
    localparam int AW  = $clog2(MEM_WORDS);
    // restoring steps for address mod MEM_WORDS
    localparam int MOD_STEPS = (MEM_WORDS >= 1024) ? 1 : $clog2(1024 / MEM_WORDS) + 1;

    typedef enum logic [8:0] {
        S_CLR  = 9'b000000001,
        S_IDLE = 9'b000000010,
        S_CMP  = 9'b000000100,
        S_ENC  = 9'b000001000,
        S_ACT  = 9'b000010000,
        S_RDW  = 9'b000100000,
        S_INS  = 9'b001000000,
        S_EV   = 9'b010000000,
        S_OUT  = 9'b100000000
    } t_state;

    function automatic logic [ADDR_W-1:0] f_mod(input logic [ADDR_W-1:0] a);
        logic [16:0] r;
        r = 17'(a);
        for (int k = MOD_STEPS - 1; k >= 0; k--)
            if (r >= 17'(MEM_WORDS << k)) r = r - 17'(MEM_WORDS << k);
        return r[ADDR_W-1:0];
    endfunction

    t_state r_state, n_state;
    logic [1:0]        r_cmd, n_cmd, r_level, n_level;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [DATA_W-1:0] r_data, n_data, r_rd, n_rd, r_ins, n_ins;
    logic              r_wb, n_wb, r_policy;
    logic [AW-1:0]     r_clr_idx;

    // word memories, one write and one registered read port each
    logic [DATA_W-1:0] r_l1_mem  [L1_ENTRIES];
    logic [DATA_W-1:0] r_l2_mem  [L2_ENTRIES];
    logic [DATA_W-1:0] r_bk_mem  [MEM_WORDS];
    logic [DATA_W-1:0] r_l1_q, r_l2_q, r_bk_q;
    logic              l1_we, l1_re, l2_we, l2_re, bk_we, bk_re;
    logic [I1W-1:0]    l1_waddr, l1_raddr;
    logic [I2W-1:0]    l2_waddr, l2_raddr;
    logic [AW-1:0]     bk_waddr, bk_raddr;
    logic [DATA_W-1:0] l1_wdata, l2_wdata, bk_wdata;

    // output register
    logic              r_ovalid, r_out_wb, out_load;
    logic [1:0]        r_out_lvl;
    logic signed [DATA_W-1:0] r_out_rd;

    // directory
    t_dir_req          dir_req;
    t_dir_stat         dir_stat;
    logic              dir_cmp;
    logic [I1W-1:0]    d_l1_idx, d_l1_tail, d_l1_head;
    logic [I2W-1:0]    d_l2_idx, d_l2_tail, d_l2_head;
    logic [ADDR_W-1:0] d_l2_head_tag;
    logic              cfg_wr;

    tfc_dir #(
        .L1_ENTRIES (L1_ENTRIES),
        .L2_ENTRIES (L2_ENTRIES)
    ) u_dir (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmp         (dir_cmp),
        .i_addr        (r_addr),
        .i_req         (dir_req),
        .o_stat        (dir_stat),
        .o_l1_idx      (d_l1_idx),
        .o_l2_idx      (d_l2_idx),
        .o_l1_tail     (d_l1_tail),
        .o_l2_tail     (d_l2_tail),
        .o_l1_head     (d_l1_head),
        .o_l2_head     (d_l2_head),
        .o_l2_head_tag (d_l2_head_tag)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign out_load   = (r_state == S_OUT) && (!r_ovalid || i_out_ready);

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_addr   = r_addr;
        n_data   = r_data;
        n_level  = r_level;
        n_rd     = r_rd;
        n_wb     = r_wb;
        n_ins    = r_ins;
        dir_req  = '0;
        dir_cmp  = 1'b0;
        l1_we    = 1'b0;
        l1_re    = 1'b0;
        l2_we    = 1'b0;
        l2_re    = 1'b0;
        bk_we    = 1'b0;
        bk_re    = 1'b0;
        l1_waddr = d_l1_tail;
        l1_raddr = d_l1_idx;
        l2_waddr = d_l2_tail;
        l2_raddr = d_l2_idx;
        bk_waddr = AW'(r_addr);
        bk_raddr = AW'(r_addr);
        l1_wdata = r_ins;
        l2_wdata = r_ins;
        bk_wdata = r_data;
        dir_req.new_dirty = (r_cmd == CMD_WRITE) && r_policy;

        unique case (r_state)
            S_CLR: begin
                bk_we    = 1'b1;
                bk_waddr = r_clr_idx;
                bk_wdata = '0;
                if (r_clr_idx == AW'(MEM_WORDS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd   = i_cmd;
                    n_addr  = f_mod(i_address);
                    n_data  = i_write_data;
                    n_rd    = '0;
                    n_wb    = 1'b0;
                    n_level = LVL_NONE;
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                dir_cmp = 1'b1;
                n_state = S_ENC;
            end
            S_ENC: n_state = S_ACT;
            S_ACT: begin
                case (r_cmd)
                    CMD_READ: begin
                        n_state = S_RDW;
                        if (dir_stat.l1_hit) begin
                            l1_re   = 1'b1;
                            n_level = LVL_L1;
                        end else if (dir_stat.l2_hit) begin
                            l2_re   = 1'b1;
                            n_level = LVL_L2;
                        end else begin
                            bk_re   = 1'b1;
                            n_level = LVL_MISS;
                        end
                    end
                    CMD_WRITE: begin
                        bk_we = !r_policy;   // write-through
                        if (dir_stat.l1_hit) begin
                            l1_we            = 1'b1;
                            l1_waddr         = d_l1_idx;
                            l1_wdata         = r_data;
                            dir_req.dirty_l1 = r_policy;
                            n_level          = LVL_L1;
                            n_state          = S_OUT;
                        end else if (dir_stat.l2_hit) begin
                            l2_we            = 1'b1;
                            l2_waddr         = d_l2_idx;
                            l2_wdata         = r_data;
                            dir_req.dirty_l2 = r_policy;
                            n_level          = LVL_L2;
                            n_state          = S_OUT;
                        end else begin
                            n_ins   = r_data;
                            n_level = LVL_MISS;
                            n_state = S_INS;
                        end
                    end
                    CMD_PRELOAD: begin
                        bk_we   = 1'b1;
                        n_state = S_OUT;
                    end
                    default: n_state = S_OUT;
                endcase
            end
            S_RDW: begin
                case (r_level)
                    LVL_L1: begin
                        n_rd    = r_l1_q;
                        n_state = S_OUT;
                    end
                    LVL_L2: begin
                        n_rd    = r_l2_q;
                        n_state = S_OUT;
                    end
                    default: begin
                        n_rd    = r_bk_q;
                        n_ins   = r_bk_q;
                        n_state = S_INS;
                    end
                endcase
            end
            S_INS: begin
                if (!dir_stat.l1_full) begin
                    l1_we          = 1'b1;
                    dir_req.ins_l1 = 1'b1;
                    n_state        = S_OUT;
                end else if (!dir_stat.l2_full) begin
                    l2_we          = 1'b1;
                    dir_req.ins_l2 = 1'b1;
                    n_state        = S_OUT;
                end else begin
                    l1_re    = 1'b1;
                    l1_raddr = d_l1_head;
                    l2_re    = 1'b1;
                    l2_raddr = d_l2_head;
                    n_state  = S_EV;
                end
            end
            S_EV: begin
                // oldest L2 word out (written back if dirty), oldest L1 word into its slot
                if (dir_stat.l2_head_dirty) begin
                    bk_we    = 1'b1;
                    bk_waddr = AW'(d_l2_head_tag);
                    bk_wdata = r_l2_q;
                    n_wb     = 1'b1;
                end
                l2_we          = 1'b1;
                l2_waddr       = d_l2_head;
                l2_wdata       = r_l1_q;
                l1_we          = 1'b1;
                l1_waddr       = d_l1_head;
                dir_req.rotate = 1'b1;
                n_state        = S_OUT;
            end
            S_OUT: begin
                if (out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (l1_we) r_l1_mem[l1_waddr] <= l1_wdata;
        if (l1_re) r_l1_q <= r_l1_mem[l1_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (l2_we) r_l2_mem[l2_waddr] <= l2_wdata;
        if (l2_re) r_l2_q <= r_l2_mem[l2_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (bk_we) r_bk_mem[bk_waddr] <= bk_wdata;
        if (bk_re) r_bk_q <= r_bk_mem[bk_raddr];
    end

    // item payload
    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_addr  <= n_addr;
        r_data  <= n_data;
        r_level <= n_level;
        r_rd    <= n_rd;
        r_wb    <= n_wb;
        r_ins   <= n_ins;
        if (out_load) begin
            r_out_rd  <= r_rd;
            r_out_lvl <= r_level;
            r_out_wb  <= r_wb;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr_idx <= '0;
            r_ovalid  <= 1'b0;
            r_policy  <= 1'b1;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) r_clr_idx <= r_clr_idx + 1'b1;
            if (out_load)         r_ovalid <= 1'b1;
            else if (i_out_ready) r_ovalid <= 1'b0;
            if (cfg_wr && paddr[2] == REG_WRITE_POLICY) r_policy <= pwdata[0];
        end
    end

    assign cfg_wr       = psel && penable && pwrite && pready;
    assign pready       = 1'b1;
    assign prdata       = (paddr[2] == REG_WRITE_POLICY) ? {31'd0, r_policy} : '0;
    assign o_out_valid  = r_ovalid;
    assign o_read_data  = r_out_rd;
    assign o_hit_level  = r_out_lvl;
    assign o_wrote_back = r_out_wb;

    // a write-back only happens on an eviction
    a_wb_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_wb && !r_wb) |-> (r_state == S_EV))
        else $error("write-back outside eviction");
    // no item taken during the clearing pass
    a_no_accept_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> !o_in_ready)
        else $error("item accepted during clear");
    // a loaded result is visible the next cycle
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (o_out_valid && r_state == S_IDLE))
        else $error("result not presented");

endmodule
